/* rtl/bfrm_pkg.sv */
// Shared constants, field widths and types of the binned frame rate meter.
// Used by bfrm_div and binned_frame_rate_meter_core.
// No dependencies.
package bfrm_pkg;

    localparam int BIN_COUNT  = 30;
    localparam int SLOT_W     = $clog2(BIN_COUNT);
    localparam int CNT_W      = $clog2(BIN_COUNT + 1);

    localparam int FT_W       = 24;
    localparam int SPAN_W     = 24;
    localparam int RB_W       = 5;
    localparam int RATE_W     = 24;
    localparam int TIME_W     = 25;
    localparam int FRAMES_W   = 16;

    localparam int CMP_W      = (RB_W > CNT_W) ? RB_W : CNT_W;
    localparam int TSUM_W     = TIME_W + $clog2(BIN_COUNT);
    localparam int FSUM_W     = FRAMES_W + $clog2(BIN_COUNT);

    // rate = frames * 256 * 1e6 / micros, UQ16.8
    localparam int SCALE_W    = 28;
    localparam logic [SCALE_W-1:0] US_SCALED = SCALE_W'(256000000);
    localparam int PROD_W     = FSUM_W + SCALE_W;
    localparam int NUM_W      = PROD_W + 1;

    localparam logic [RATE_W-1:0]   RATE_MAX   = {RATE_W{1'b1}};
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = {FRAMES_W{1'b1}};

    localparam logic [SPAN_W-1:0] SPAN_RESET   = SPAN_W'(250000);
    localparam logic [RB_W-1:0]   RECENT_RESET = RB_W'(8);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SPAN    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RECENT_BINS = CFG_IDX_W'(1);

    typedef struct packed {
        logic [TIME_W-1:0]   bin_time;
        logic [FRAMES_W-1:0] bin_frames;
    } bin_entry_t;

    typedef struct packed {
        logic              start;
        logic [FSUM_W-1:0] frames;
        logic [TSUM_W-1:0] micros;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/bfrm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bfrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bfrm_div.sv */
// Rate divider: frames * 256e6 + micros/2 over micros, one quotient bit per cycle.
// Saturates to the largest rate, which also covers a zero divisor.
// Depends on bfrm_pkg.
module bfrm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bfrm_pkg::div_req_t req,
    output bfrm_pkg::div_rsp_t rsp
);
    import bfrm_pkg::*;

    localparam int SAT_W = (NUM_W > TSUM_W + RATE_W) ? NUM_W : TSUM_W + RATE_W;
    localparam int BIT_W = $clog2(RATE_W);

    typedef enum logic [4:0] {
        D_IDLE  = 5'b00001,
        D_MUL   = 5'b00010,
        D_ADD   = 5'b00100,
        D_CHECK = 5'b01000,
        D_RUN   = 5'b10000
    } div_state_t;

    div_state_t        state_reg, state_next;
    logic [FSUM_W-1:0] frames_reg;
    logic [TSUM_W-1:0] micros_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [TSUM_W-1:0] rem_reg;
    logic [RATE_W-1:0] lo_reg;
    logic [RATE_W-1:0] q_reg;
    logic [BIT_W-1:0]  bit_cnt_reg;
    logic              done_reg, done_next;

    logic              sat;
    logic [TSUM_W:0]   trial;
    logic              ge;

    assign sat   = SAT_W'(num_reg) >= SAT_W'({micros_reg, {RATE_W{1'b0}}});
    assign trial = {rem_reg, lo_reg[RATE_W-1]};
    assign ge    = trial >= {1'b0, micros_reg};

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    state_next = D_MUL;
                end
            end
            D_MUL:   state_next = D_ADD;
            D_ADD:   state_next = D_CHECK;
            D_CHECK:
            begin
                if (sat)
                begin
                    state_next = D_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = D_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    frames_reg <= req.frames;
                    micros_reg <= req.micros;
                end
            end
            D_MUL:   prod_reg <= frames_reg * US_SCALED;
            D_ADD:   num_reg <= {1'b0, prod_reg} + NUM_W'(micros_reg >> 1);
            D_CHECK:
            begin
                if (sat)
                begin
                    q_reg <= RATE_MAX;
                end
                else
                begin
                    // Below saturation the upper part is already less than the divisor
                    rem_reg     <= TSUM_W'(num_reg >> RATE_W);
                    lo_reg      <= num_reg[RATE_W-1:0];
                    bit_cnt_reg <= BIT_W'(RATE_W - 1);
                end
            end
            D_RUN:
            begin
                rem_reg     <= ge ? TSUM_W'(trial - {1'b0, micros_reg}) : TSUM_W'(trial);
                lo_reg      <= {lo_reg[RATE_W-2:0], 1'b0};
                q_reg       <= {q_reg[RATE_W-2:0], ge};
                bit_cnt_reg <= bit_cnt_reg - BIT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

/* rtl/binned_frame_rate_meter_core.sv */
// Top level of the binned frame rate meter: bin ring, window sums, output register.
// Depends on bfrm_pkg, bfrm_ram and bfrm_div.
//
//   channel   signals                             width
//   in        in_valid/in_ready, frame_time       24
//   out       out_valid/out_ready, recent_rate,   24, 24
//             smooth_rate
//   cfg       cfg_we, cfg_index, cfg_data         1, 2, 24
//
// Per beat, the bin ring RAM is swept one entry a cycle over the bins kept (1 to 30),
// then one shared divider produces each rate, recent then smooth, at one quotient bit a
// cycle, ending early when the rate saturates. The next beat is taken only once the
// result has been loaded into the output register.
// A new beat is taken while the previous result still sits in the output register.
// Reset empties the ring; bin contents need no clearing.
module binned_frame_rate_meter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bfrm_pkg::FT_W-1:0]       frame_time,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bfrm_pkg::RATE_W-1:0]     recent_rate,
    output logic [bfrm_pkg::RATE_W-1:0]     smooth_rate,
    input  logic                            cfg_we,
    input  logic [bfrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfrm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bfrm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_UPDATE     = 6'b000010,
        ST_SUM        = 6'b000100,
        ST_DIV_RECENT = 6'b001000,
        ST_DIV_SMOOTH = 6'b010000,
        ST_PUSH       = 6'b100000
    } state_t;

    state_t              state_reg, state_next;

    logic [SPAN_W-1:0]   bin_span_reg;
    logic [RB_W-1:0]     recent_bins_reg;

    logic [FT_W-1:0]     ft_reg;
    logic [TIME_W-1:0]   cur_time_reg;
    logic [FRAMES_W-1:0] cur_frames_reg;
    logic [SLOT_W-1:0]   newest_slot_reg;
    logic [CNT_W-1:0]    bins_used_reg;
    logic [CNT_W-1:0]    win_reg;

    logic [SLOT_W-1:0]   rd_slot_reg;
    logic [CNT_W-1:0]    issue_cnt_reg;
    logic [CNT_W-1:0]    acc_cnt_reg;
    logic                rd_pend_reg;
    logic [TSUM_W-1:0]   t_sum_reg;
    logic [FSUM_W-1:0]   f_sum_reg;
    logic [TSUM_W-1:0]   rec_t_reg;
    logic [FSUM_W-1:0]   rec_f_reg;

    logic                div_start_reg;
    logic [RATE_W-1:0]   recent_q_reg;
    logic [RATE_W-1:0]   smooth_q_reg;

    logic                out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]   recent_rate_reg;
    logic [RATE_W-1:0]   smooth_rate_reg;

    logic                in_accept;
    logic                absorb;
    logic [SLOT_W-1:0]   next_slot;
    logic [SLOT_W-1:0]   prev_rd_slot;
    logic [CNT_W-1:0]    bins_used_next;
    logic [RB_W-1:0]     recent_eff;
    logic [CNT_W-1:0]    win_next;
    logic [TIME_W-1:0]   new_time;
    logic [FRAMES_W-1:0] new_frames;
    bin_entry_t          wr_entry;
    bin_entry_t          rd_entry;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic                issue;
    logic [TSUM_W-1:0]   t_sum_next;
    logic [FSUM_W-1:0]   f_sum_next;
    logic                sum_done;
    logic                out_load;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // Ring bookkeeping for the incoming frame
    assign absorb    = (bins_used_reg != '0) && ({1'b0, bin_span_reg} > cur_time_reg);
    assign next_slot = (newest_slot_reg == SLOT_W'(BIN_COUNT - 1)) ? '0
                                                                   : newest_slot_reg + SLOT_W'(1);
    assign bins_used_next = (!absorb && bins_used_reg != CNT_W'(BIN_COUNT))
                          ? bins_used_reg + CNT_W'(1) : bins_used_reg;
    assign new_time   = absorb ? cur_time_reg + TIME_W'(ft_reg) : TIME_W'(ft_reg);
    assign new_frames = !absorb ? FRAMES_W'(1)
                      : (cur_frames_reg == FRAMES_MAX) ? cur_frames_reg
                      : cur_frames_reg + FRAMES_W'(1);

    assign recent_eff = (recent_bins_reg == '0) ? RB_W'(1) : recent_bins_reg;
    assign win_next   = (CMP_W'(recent_eff) > CMP_W'(bins_used_next)) ? bins_used_next
                                                                      : CNT_W'(recent_eff);

    assign wr_entry.bin_time   = new_time;
    assign wr_entry.bin_frames = new_frames;
    assign ram_we    = (state_reg == ST_UPDATE);
    assign ram_waddr = absorb ? newest_slot_reg : next_slot;

    // Sweep from the newest bin backward
    assign prev_rd_slot = (rd_slot_reg == '0) ? SLOT_W'(BIN_COUNT - 1)
                                              : rd_slot_reg - SLOT_W'(1);
    assign issue      = (state_reg == ST_SUM) && (issue_cnt_reg != bins_used_reg);
    assign t_sum_next = t_sum_reg + TSUM_W'(rd_entry.bin_time);
    assign f_sum_next = f_sum_reg + FSUM_W'(rd_entry.bin_frames);
    assign sum_done   = (acc_cnt_reg == bins_used_reg) && !rd_pend_reg;

    assign out_load   = (state_reg == ST_PUSH) && (!out_valid_reg || out_ready);

    bfrm_ram #(
        .WIDTH ($bits(bin_entry_t)),
        .DEPTH (BIN_COUNT)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (rd_slot_reg),
        .rdata (rd_entry)
    );

    assign div_req.start  = div_start_reg;
    assign div_req.frames = (state_reg == ST_DIV_SMOOTH) ? f_sum_reg : rec_f_reg;
    assign div_req.micros = (state_reg == ST_DIV_SMOOTH) ? t_sum_reg : rec_t_reg;

    bfrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_SUM;
            ST_SUM:
            begin
                if (sum_done)
                begin
                    state_next = ST_DIV_RECENT;
                end
            end
            ST_DIV_RECENT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_SMOOTH;
                end
            end
            ST_DIV_SMOOTH:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bin_span_reg    <= SPAN_RESET;
            recent_bins_reg <= RECENT_RESET;
            newest_slot_reg <= SLOT_W'(BIN_COUNT - 1);
            bins_used_reg   <= '0;
            issue_cnt_reg   <= '0;
            acc_cnt_reg     <= '0;
            rd_pend_reg     <= 1'b0;
            div_start_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= issue;
            div_start_reg <= ((state_reg == ST_SUM) && sum_done)
                          || ((state_reg == ST_DIV_RECENT) && div_rsp.done);

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BIN_SPAN:    bin_span_reg    <= SPAN_W'(cfg_data);
                    REG_RECENT_BINS: recent_bins_reg <= RB_W'(cfg_data);
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_UPDATE)
            begin
                bins_used_reg <= bins_used_next;
                issue_cnt_reg <= '0;
                acc_cnt_reg   <= '0;
                if (!absorb)
                begin
                    newest_slot_reg <= next_slot;
                end
            end

            if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            if (rd_pend_reg)
            begin
                acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ft_reg <= frame_time;
        end

        if (state_reg == ST_UPDATE)
        begin
            cur_time_reg   <= new_time;
            cur_frames_reg <= new_frames;
            win_reg        <= win_next;
            rd_slot_reg    <= ram_waddr;
            t_sum_reg      <= '0;
            f_sum_reg      <= '0;
        end
        else if (issue)
        begin
            rd_slot_reg <= prev_rd_slot;
        end

        if (rd_pend_reg)
        begin
            t_sum_reg <= t_sum_next;
            f_sum_reg <= f_sum_next;
            // Snapshot once the newest win_reg bins are in
            if (acc_cnt_reg + CNT_W'(1) == win_reg)
            begin
                rec_t_reg <= t_sum_next;
                rec_f_reg <= f_sum_next;
            end
        end

        if ((state_reg == ST_DIV_RECENT) && div_rsp.done)
        begin
            recent_q_reg <= div_rsp.quotient;
        end
        if ((state_reg == ST_DIV_SMOOTH) && div_rsp.done)
        begin
            smooth_q_reg <= div_rsp.quotient;
        end

        if (out_load)
        begin
            recent_rate_reg <= recent_q_reg;
            smooth_rate_reg <= smooth_q_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign recent_rate = recent_rate_reg;
    assign smooth_rate = smooth_rate_reg;

`ifndef NO_ASSERTIONS
    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_UPDATE))
        else $error("accepted beat did not move to bin update");

    a_bins_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (bins_used_reg <= CNT_W'(BIN_COUNT)) && (issue_cnt_reg <= bins_used_reg))
        else $error("bin count or read sweep out of range");

    a_window_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (win_reg != '0) && (win_reg <= bins_used_reg))
        else $error("recent window outside kept bins");

    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_RECENT) || (state_reg == ST_DIV_SMOOTH))
        else $error("divider finished with no request in flight");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(recent_rate_reg)
                                          && $stable(smooth_rate_reg))
        else $error("pending result overwritten");
`endif

endmodule
